// ===== design/kv_block_entry_deframer_macros.svh =====
// ---------------------------------------------------------------------------
// kv_block_entry_deframer_macros.svh
// Assertion macros used by the entry deframer top module.
// ---------------------------------------------------------------------------
`ifndef KV_BLOCK_ENTRY_DEFRAMER_MACROS_SVH
`define KV_BLOCK_ENTRY_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define KVBED_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define KVBED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/kvbed_pkg.sv =====
// ---------------------------------------------------------------------------
// kvbed_pkg
// Types and codes shared by the entry deframer modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package kvbed_pkg;

  // Parser phase, one-hot.
  typedef enum logic [5:0] {
    PH_START   = 6'b000001,
    PH_KEYLEN  = 6'b000010,
    PH_VALLEN  = 6'b000100,
    PH_KEY     = 6'b001000,
    PH_VALUE   = 6'b010000,
    PH_DISCARD = 6'b100000
  } phase_t;

  // Byte classification codes.
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_KEY     = 2'd1,
    KIND_VALUE   = 2'd2,
    KIND_DISCARD = 2'd3
  } kind_t;

  // A varint32 holds at most five bytes; the seen count stops at four.
  localparam logic [2:0] VARINT_LAST_IDX = 3'd4;

  // Parser state carried from byte to byte.
  typedef struct packed {
    phase_t      phase;
    logic [31:0] varint_accum;
    logic [2:0]  varint_bytes_seen;
    logic [31:0] key_len_hold;
    logic [31:0] val_len_hold;
    logic [31:0] bytes_remaining;
  } state_t;

  // Result for one byte.
  typedef struct packed {
    logic [7:0]  byte_out;
    kind_t       kind;
    logic        entry_start;
    logic        entry_done;
    logic [31:0] key_len;
    logic [31:0] val_len;
    logic        corrupt;
  } result_t;

endpackage

// ===== design/kvbed_step.sv =====
// ---------------------------------------------------------------------------
// kvbed_step
// Per-byte decode: next parser state and the result for one block byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvbed_step (
  input  kvbed_pkg::state_t  state_cur,
  input  logic [7:0]         data_byte,
  input  logic               block_end,
  output kvbed_pkg::state_t  state_nxt,
  output kvbed_pkg::result_t result
);
  import kvbed_pkg::*;

  logic [31:0] base_accum;
  logic [2:0]  base_seen;
  logic [4:0]  vshift;
  logic [31:0] v_accum;
  logic        v_more;
  logic        v_bad;
  logic [2:0]  v_seen_inc;
  logic [31:0] rem_dec;

  // Varint byte: a new entry starts from a cleared accumulator.
  always_comb begin
    if (state_cur.phase == PH_START) begin
      base_accum = '0;
      base_seen  = '0;
    end else begin
      base_accum = state_cur.varint_accum;
      base_seen  = state_cur.varint_bytes_seen;
    end
    case (base_seen)
      3'd0:    vshift = 5'd0;
      3'd1:    vshift = 5'd7;
      3'd2:    vshift = 5'd14;
      3'd3:    vshift = 5'd21;
      default: vshift = 5'd28;
    endcase
    // Bits of the fifth byte above bit 31 fall off the shift.
    v_accum    = base_accum | ({25'd0, data_byte[6:0]} << vshift);
    v_more     = data_byte[7];
    v_bad      = v_more && (base_seen >= VARINT_LAST_IDX);
    v_seen_inc = base_seen + 3'd1;
  end

  // Saturating count of key or value bytes still to come.
  assign rem_dec = (state_cur.bytes_remaining != 32'd0) ?
                   (state_cur.bytes_remaining - 32'd1) : 32'd0;

  // Phase logic.
  always_comb begin
    logic  start;
    logic  done;
    logic  bad;
    kind_t kind;

    state_nxt = state_cur;
    start     = 1'b0;
    done      = 1'b0;
    bad       = 1'b0;
    kind      = KIND_HEADER;

    case (state_cur.phase)
      PH_START: begin
        start                       = 1'b1;
        state_nxt.varint_accum      = '0;
        state_nxt.varint_bytes_seen = '0;
        if (block_end) begin
          bad = 1'b1;
        end else if (!v_more) begin
          state_nxt.key_len_hold = v_accum;
          state_nxt.phase        = PH_VALLEN;
        end else begin
          state_nxt.varint_accum      = v_accum;
          state_nxt.varint_bytes_seen = v_seen_inc;
          state_nxt.phase             = PH_KEYLEN;
        end
      end
      PH_KEYLEN: begin
        state_nxt.varint_accum = v_accum;
        if (v_more && !v_bad) begin
          state_nxt.varint_bytes_seen = v_seen_inc;
        end
        if (v_bad || block_end) begin
          bad = 1'b1;
        end else if (!v_more) begin
          state_nxt.key_len_hold      = v_accum;
          state_nxt.varint_accum      = '0;
          state_nxt.varint_bytes_seen = '0;
          state_nxt.phase             = PH_VALLEN;
        end
      end
      PH_VALLEN: begin
        state_nxt.varint_accum = v_accum;
        if (v_more && !v_bad) begin
          state_nxt.varint_bytes_seen = v_seen_inc;
        end
        if (v_bad) begin
          bad = 1'b1;
        end else if (v_more) begin
          bad = block_end;
        end else begin
          state_nxt.val_len_hold = v_accum;
          if ((state_cur.key_len_hold == 32'd0) && (v_accum == 32'd0)) begin
            done = 1'b1;
          end else if (block_end) begin
            bad = 1'b1;
          end else if (state_cur.key_len_hold != 32'd0) begin
            state_nxt.bytes_remaining = state_cur.key_len_hold;
            state_nxt.phase           = PH_KEY;
          end else begin
            state_nxt.bytes_remaining = v_accum;
            state_nxt.phase           = PH_VALUE;
          end
        end
      end
      PH_KEY: begin
        kind                      = KIND_KEY;
        state_nxt.bytes_remaining = rem_dec;
        if (rem_dec == 32'd0) begin
          if (state_cur.val_len_hold == 32'd0) begin
            done = 1'b1;
          end else if (block_end) begin
            bad = 1'b1;
          end else begin
            state_nxt.bytes_remaining = state_cur.val_len_hold;
            state_nxt.phase           = PH_VALUE;
          end
        end else begin
          bad = block_end;
        end
      end
      PH_VALUE: begin
        kind                      = KIND_VALUE;
        state_nxt.bytes_remaining = rem_dec;
        if (rem_dec == 32'd0) begin
          done = 1'b1;
        end else begin
          bad = block_end;
        end
      end
      default: begin
        // Discarding to the end of a corrupt block.
        kind = KIND_DISCARD;
        if (block_end) begin
          state_nxt.phase = PH_START;
        end
      end
    endcase

    // A bad entry overrides everything and drops the rest of the block.
    if (bad) begin
      kind            = KIND_DISCARD;
      done            = 1'b0;
      state_nxt.phase = block_end ? PH_START : PH_DISCARD;
    end else if (done) begin
      state_nxt.phase = PH_START;
    end

    result.byte_out    = data_byte;
    result.kind        = kind;
    result.entry_start = start;
    result.entry_done  = done;
    result.key_len     = done ? state_nxt.key_len_hold : 32'd0;
    result.val_len     = done ? state_nxt.val_len_hold : 32'd0;
    result.corrupt     = bad;
  end

endmodule

// ===== design/kv_block_entry_deframer.sv =====
// ---------------------------------------------------------------------------
// kv_block_entry_deframer
// Splits storage-block bytes into varint-prefixed key/value entries.
// ---------------------------------------------------------------------------
// Usage:
//   Feed block bytes in order on the in_ channel, with in_block_end high on
//   the final byte of each block. Every accepted byte produces exactly one
//   request on the out_ channel: the byte itself, its kind (header, key,
//   value or discarded), entry start and entry done flags, both decoded
//   lengths on the completing byte, and a corrupt flag.
//   out_valid rises in the cycle after input acceptance. Throughput is one
//   byte per cycle while the receiver keeps up: the byte decode is a single
//   pass of logic between the parser state and output registers.
//   The input is ready whenever the output register is empty or being taken
//   in the same cycle, so a stalled receiver holds the pending result and
//   stops input acceptance until it drains.
//   A corrupt entry marks its byte and discards bytes up to the end of the
//   block; parsing resumes with the next block.
//   Synchronous reset returns the parser to the start of an entry and
//   empties the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "kv_block_entry_deframer_macros.svh"

module kv_block_entry_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_block_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte_out,
  output logic [1:0]  out_kind,
  output logic        out_entry_start,
  output logic        out_entry_done,
  output logic [31:0] out_key_len,
  output logic [31:0] out_val_len,
  output logic        out_corrupt
);
  import kvbed_pkg::*;

  state_t  state_r;
  state_t  state_nxt;
  result_t result_nxt;
  result_t result_r;
  logic    out_valid_r;
  logic    in_accept;

  // Accept when the output register is free or drains this cycle.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  kvbed_step u_step (
    .state_cur (state_r),
    .data_byte (in_data_byte),
    .block_end (in_block_end),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // Parser state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase             <= PH_START;
      state_r.varint_accum      <= '0;
      state_r.varint_bytes_seen <= '0;
      state_r.key_len_hold      <= '0;
      state_r.val_len_hold      <= '0;
      state_r.bytes_remaining   <= '0;
      out_valid_r               <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r <= state_nxt;
      end
      if (in_ready) begin
        out_valid_r <= in_valid;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_out    = result_r.byte_out;
  assign out_kind        = 2'(result_r.kind);
  assign out_entry_start = result_r.entry_start;
  assign out_entry_done  = result_r.entry_done;
  assign out_key_len     = result_r.key_len;
  assign out_val_len     = result_r.val_len;
  assign out_corrupt     = result_r.corrupt;

  // A block end always returns the parser to the start of an entry.
  `KVBED_ASSERT_NEXT(a_end_restarts, in_accept && in_block_end, state_r.phase == PH_START, "block end did not restart parser")

  // A corrupt byte is never also a completed entry, and is discarded.
  `KVBED_ASSERT_IMPL(a_corrupt_discard, out_valid_r && out_corrupt, !out_entry_done && (result_r.kind == KIND_DISCARD), "corrupt byte not discarded")

  // An entry start byte is header or discarded.
  `KVBED_ASSERT_IMPL(a_start_kind, out_valid_r && out_entry_start, (result_r.kind == KIND_HEADER) || (result_r.kind == KIND_DISCARD), "entry start with payload kind")

  // Lengths are zero unless the entry completes.
  `KVBED_ASSERT_IMPL(a_len_zero, out_valid_r && !out_entry_done, (out_key_len == 32'd0) && (out_val_len == 32'd0), "length shown without entry done")

endmodule
